### sv/nearest_palette_color_search_top_defines.svh
// Assertion macros shared by the checker.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication.
`define NPCS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npcs assertion failed");

// Next-cycle implication.
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npcs assertion failed");

`endif

### sv/npcs_pkg.sv
package npcs_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   localparam int INDEX_W    = 8;
   localparam int COLOR_W    = 8;
   localparam int DISTANCE_W = 18;
   localparam int CSR_INDEX_W = 1;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_INDEX = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX  = 1'b1;

   localparam logic [INDEX_W-1:0] FIRST_INDEX_RESET = 8'd2;
   localparam logic [INDEX_W-1:0] LAST_INDEX_RESET  = 8'd254;

   localparam logic [DISTANCE_W-1:0] NO_MATCH_DISTANCE = 18'h3FFFF;

   typedef struct packed {
      logic               mode;
      logic [INDEX_W-1:0] entry_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } npcs_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]    best_index;
      logic [DISTANCE_W-1:0] best_distance;
   } npcs_rsp_type;

   typedef struct packed {
      logic pal_write;
      logic query_load;
      logic scan_read;
   } npcs_cmd_type;

   typedef struct packed {
      logic range_empty;
      logic scan_last;
      logic pipe_busy;
   } npcs_status_type;

endpackage

### sv/npcs_ctrl.sv
module npcs_ctrl
   import npcs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_mode,
   input  npcs_status_type status,
   output npcs_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign accept         = start && (state_ff == ST_IDLE);
   assign cmd.pal_write  = accept && (req_mode == MODE_WRITE);
   assign cmd.query_load = accept && (req_mode == MODE_QUERY);
   assign cmd.scan_read  = (state_ff == ST_SCAN);
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.query_load) begin
               state_in = status.range_empty ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/npcs_datapath.sv
module npcs_datapath
   import npcs_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  npcs_req_type           req_data,
   input  npcs_cmd_type           cmd,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [INDEX_W-1:0]     csr_wdata,
   output npcs_status_type        status,
   output npcs_rsp_type           rsp_data
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [INDEX_W:0]   ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);
   localparam logic [INDEX_W-1:0] LAST_SLOT   = INDEX_W'(PALETTE_ENTRIES - 1);
   localparam int ENTRY_W = 3 * COLOR_W;
   localparam int SQ_W    = 2 * COLOR_W;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   logic [ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];

   logic [INDEX_W-1:0]    first_ff;
   logic [INDEX_W-1:0]    last_ff;
   logic [INDEX_W-1:0]    hi_index;
   logic [INDEX_W-1:0]    scan_idx_ff;
   logic [COLOR_W-1:0]    q_red_ff;
   logic [COLOR_W-1:0]    q_green_ff;
   logic [COLOR_W-1:0]    q_blue_ff;
   logic                  rd_valid_ff;
   logic [INDEX_W-1:0]    rd_idx_ff;
   logic [ENTRY_W-1:0]    rdata_ff;
   logic                  sq_valid_ff;
   logic [INDEX_W-1:0]    sq_idx_ff;
   logic [SQ_W-1:0]       sq_r_ff;
   logic [SQ_W-1:0]       sq_g_ff;
   logic [SQ_W-1:0]       sq_b_ff;
   logic [DISTANCE_W-1:0] dist_sum;
   logic [INDEX_W-1:0]    best_idx_ff;
   logic [INDEX_W-1:0]    best_idx_in;
   logic [DISTANCE_W-1:0] best_dist_ff;
   logic [DISTANCE_W-1:0] best_dist_in;
   logic [COLOR_W-1:0]    d_r;
   logic [COLOR_W-1:0]    d_g;
   logic [COLOR_W-1:0]    d_b;

   assign hi_index = (last_ff > LAST_SLOT) ? LAST_SLOT : last_ff;

   assign status.range_empty = (first_ff > hi_index);
   assign status.scan_last   = (scan_idx_ff == hi_index);
   assign status.pipe_busy   = rd_valid_ff || sq_valid_ff;

   assign rsp_data.best_index    = best_idx_ff;
   assign rsp_data.best_distance = best_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= FIRST_INDEX_RESET;
         last_ff  <= LAST_INDEX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_INDEX: first_ff <= csr_wdata;
            CSR_LAST_INDEX:  last_ff  <= csr_wdata;
            default:         first_ff <= first_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pal_write && ({1'b0, req_data.entry_index} < ENTRY_LIMIT)) begin
         palette_mem[req_data.entry_index[AW-1:0]] <=
            {req_data.red, req_data.green, req_data.blue};
      end
      if (cmd.scan_read) begin
         rdata_ff <= palette_mem[scan_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_load) begin
         q_red_ff    <= req_data.red;
         q_green_ff  <= req_data.green;
         q_blue_ff   <= req_data.blue;
         scan_idx_ff <= first_ff;
      end else if (cmd.scan_read) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      rd_idx_ff <= scan_idx_ff;
      sq_idx_ff <= rd_idx_ff;
      sq_r_ff   <= d_r * d_r;
      sq_g_ff   <= d_g * d_g;
      sq_b_ff   <= d_b * d_b;
   end

   assign d_r = abs_diff(rdata_ff[ENTRY_W-1 -: COLOR_W], q_red_ff);
   assign d_g = abs_diff(rdata_ff[2*COLOR_W-1 -: COLOR_W], q_green_ff);
   assign d_b = abs_diff(rdata_ff[COLOR_W-1:0], q_blue_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_read;
         sq_valid_ff <= rd_valid_ff;
      end
   end

   assign dist_sum = DISTANCE_W'(sq_r_ff) + DISTANCE_W'(sq_g_ff) + DISTANCE_W'(sq_b_ff);

   always_comb begin
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      priority if (cmd.query_load) begin
         best_idx_in  = first_ff;
         best_dist_in = NO_MATCH_DISTANCE;
      end else if (sq_valid_ff && (dist_sum < best_dist_ff)) begin
         best_idx_in  = sq_idx_ff;
         best_dist_in = dist_sum;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
   end

endmodule

### sv/nearest_palette_color_search_top.sv
// Nearest palette color search.
// Input items arrive on start/busy with req_data; an item is taken at a rising
// edge with start high and busy low. mode MODE_WRITE stores an RGB entry, gives
// no result and leaves busy low. mode MODE_QUERY searches the entries
// first_index..last_index (last_index clamped to the last palette entry).
// rsp_valid strobes for one cycle once the scan has read every entry and the
// pipeline has drained; busy stays high until that strobe ends, so the next
// item is taken only after it. An empty range answers in the cycle after the
// accepting edge with first_index and distance all ones. The rate is set by
// the single-port palette memory, read one entry per cycle into a three-stage
// square-and-compare pipeline.
// The receiver cannot stall: rsp_data is valid only during the rsp_valid cycle.
// The csr port (index 0 first_index, index 1 last_index) is ready while idle
// and no item is offered on start.
// Reset clears the controller and restores first_index 2 and last_index 254;
// palette contents are undefined until written.
module nearest_palette_color_search_top
   import npcs_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  npcs_req_type           req_data,
   output logic                   rsp_valid,
   output npcs_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [INDEX_W-1:0]     csr_wdata
);

   npcs_cmd_type    cmd;
   npcs_status_type status;

   assign csr_ready = !busy && !start;

   npcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_data.mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   npcs_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/npcs_checker.sv
`include "nearest_palette_color_search_top_defines.svh"

module npcs_checker
   import npcs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input npcs_req_type req_data,
   input logic         rsp_valid
);

   `NPCS_ASSERT_NEXT(a_query_sets_busy, clock, reset, start && !busy && (req_data.mode == MODE_QUERY), busy)
   `NPCS_ASSERT_NEXT(a_write_stays_idle, clock, reset, start && !busy && (req_data.mode == MODE_WRITE), !busy && !rsp_valid)
   `NPCS_ASSERT_IMPLIES(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `NPCS_ASSERT_NEXT(a_rsp_ends_item, clock, reset, rsp_valid, !busy && !rsp_valid)

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (.*);
